>>> hw/rtl/rqf_pkg.sv
`default_nettype none
package rqf_pkg;

  localparam int OP_W   = 2;
  localparam int TASK_W = 8;
  localparam int ST_W   = 3;

  localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE  = 2'd2;

  localparam logic [ST_W-1:0] ST_ENQUEUED  = 3'd0;
  localparam logic [ST_W-1:0] ST_ALREADY   = 3'd1;
  localparam logic [ST_W-1:0] ST_DEQUEUED  = 3'd2;
  localparam logic [ST_W-1:0] ST_EMPTY     = 3'd3;
  localparam logic [ST_W-1:0] ST_REMOVED   = 3'd4;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd5;

  // Sequencer states of the queue engine.
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_WALK,
    S_CMP,
    S_LINK,
    S_RESP
  } state_t;

endpackage
`default_nettype wire

>>> hw/rtl/run_queue_fifo_with_removal_core.sv
`default_nettype none
// FIFO run queue of task slot numbers with removal from any position. The
// queue is a singly linked list kept in a one-port-read, one-port-write link
// memory (one successor per slot), plus one membership flag per slot in
// flip-flops that reset clears, so the block is usable right after reset.
// One item is handled at a time; in_ready is high while the engine is idle,
// even while the previous result still waits in the output register. An
// enqueue passes the execute and response steps; a dequeue or a remove of
// the head adds a pop step if more than one slot is queued. A remove
// elsewhere walks from the head to find the predecessor, a read step then
// a compare step per link visited, since every link comes from the single
// read port of the link memory, plus a link step to splice past the removed
// slot unless it is the tail. Only slots below both TASK_SLOTS and 256 can
// ever be queued; other slot numbers answer already queued or not found.
module run_queue_fifo_with_removal_core #(
  parameter int TASK_SLOTS = 256
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire  [rqf_pkg::OP_W-1:0]    in_operation,
  input  wire  [rqf_pkg::TASK_W-1:0]  in_task_id,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic [rqf_pkg::ST_W-1:0]    out_status,
  output logic [rqf_pkg::TASK_W-1:0]  out_task_out
);
  import rqf_pkg::*;

  // Slot numbers are 8 bits wide, so no more than 256 slots are reachable.
  localparam int DEPTH = (TASK_SLOTS < 256) ? TASK_SLOTS : 256;
  localparam int IDX_W = $clog2(DEPTH);

  function automatic logic [IDX_W-1:0] to_idx(input logic [TASK_W-1:0] slot);
    return slot[IDX_W-1:0];
  endfunction

  // Control state
  state_t state_r, state_nxt;
  logic             empty_r, empty_nxt;
  logic [DEPTH-1:0] queued_r, queued_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Item and working registers
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [TASK_W-1:0] task_r, task_nxt;
  logic [TASK_W-1:0] head_r, head_nxt;
  logic [TASK_W-1:0] tail_r, tail_nxt;
  logic [TASK_W-1:0] prev_r, prev_nxt;
  logic [ST_W-1:0]   status_r, status_nxt;
  logic [TASK_W-1:0] popped_r, popped_nxt;
  logic [ST_W-1:0]   out_status_r, out_status_nxt;
  logic [TASK_W-1:0] out_task_r, out_task_nxt;

  // Link memory
  logic [TASK_W-1:0] link_mem [DEPTH];
  logic [TASK_W-1:0] rd_data_r;
  logic              link_we, link_re;
  logic [IDX_W-1:0]  link_waddr, link_raddr;
  logic [TASK_W-1:0] link_wdata;

  // Shared decode of the held item against the queue state
  logic t_in_range, t_queued, t_is_head, t_is_tail, hd_is_tl, prev_is_tail, rd_match;
  logic out_free;

  assign t_in_range   = {5'd0, task_r} < 13'(DEPTH);
  assign t_queued     = t_in_range && queued_r[to_idx(task_r)];
  assign t_is_head    = task_r == head_r;
  assign t_is_tail    = task_r == tail_r;
  assign hd_is_tl     = head_r == tail_r;
  assign prev_is_tail = prev_r == tail_r;
  assign rd_match     = rd_data_r == task_r;
  assign out_free     = !out_valid_r || out_ready;

  assign in_ready     = state_r == S_IDLE;
  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_task_out = out_task_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_RESP;
        unique case (op_r)
          OP_DEQUEUE: begin
            if (!empty_r && !hd_is_tl) state_nxt = S_POP;
          end
          OP_REMOVE: begin
            if (t_queued && !empty_r) begin
              if (!t_is_head)     state_nxt = S_WALK;
              else if (!hd_is_tl) state_nxt = S_POP;
            end
          end
          default: state_nxt = S_RESP;
        endcase
      end
      S_POP:  state_nxt = S_RESP;
      S_WALK: state_nxt = prev_is_tail ? S_RESP : S_CMP;
      S_CMP: begin
        if (!rd_match)      state_nxt = S_WALK;
        else if (t_is_tail) state_nxt = S_RESP;
        else                state_nxt = S_LINK;
      end
      S_LINK: state_nxt = S_RESP;
      S_RESP: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    op_nxt         = op_r;
    task_nxt       = task_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    prev_nxt       = prev_r;
    empty_nxt      = empty_r;
    queued_nxt     = queued_r;
    status_nxt     = status_r;
    popped_nxt     = popped_r;
    out_status_nxt = out_status_r;
    out_task_nxt   = out_task_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    link_we        = 1'b0;
    link_waddr     = '0;
    link_wdata     = '0;
    link_re        = 1'b0;
    link_raddr     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt   = in_operation;
          task_nxt = in_task_id;
        end
      end
      S_EXEC: begin
        popped_nxt = '0;
        status_nxt = ST_NOT_FOUND;
        unique case (op_r)
          OP_ENQUEUE: begin
            if (!t_in_range || t_queued) begin
              status_nxt = ST_ALREADY;
            end else begin
              // append behind the tail, or start a fresh list
              if (empty_r) begin
                head_nxt  = task_r;
                empty_nxt = 1'b0;
              end else begin
                link_we    = 1'b1;
                link_waddr = to_idx(tail_r);
                link_wdata = task_r;
              end
              tail_nxt                   = task_r;
              queued_nxt[to_idx(task_r)] = 1'b1;
              status_nxt                 = ST_ENQUEUED;
            end
          end
          OP_DEQUEUE: begin
            if (empty_r) begin
              status_nxt = ST_EMPTY;
            end else begin
              popped_nxt                 = head_r;
              status_nxt                 = ST_DEQUEUED;
              queued_nxt[to_idx(head_r)] = 1'b0;
              if (hd_is_tl) begin
                empty_nxt = 1'b1;
              end else begin
                link_re    = 1'b1;
                link_raddr = to_idx(head_r);
              end
            end
          end
          OP_REMOVE: begin
            if (t_queued && !empty_r) begin
              if (t_is_head) begin
                // same as a pop, but report no slot
                status_nxt                 = ST_REMOVED;
                queued_nxt[to_idx(head_r)] = 1'b0;
                if (hd_is_tl) begin
                  empty_nxt = 1'b1;
                end else begin
                  link_re    = 1'b1;
                  link_raddr = to_idx(head_r);
                end
              end else begin
                prev_nxt = head_r;
              end
            end
          end
          default: status_nxt = ST_NOT_FOUND;
        endcase
      end
      S_POP: begin
        head_nxt = rd_data_r;
      end
      S_WALK: begin
        if (prev_is_tail) begin
          status_nxt = ST_NOT_FOUND;
        end else begin
          link_re    = 1'b1;
          link_raddr = to_idx(prev_r);
        end
      end
      S_CMP: begin
        if (rd_match) begin
          queued_nxt[to_idx(task_r)] = 1'b0;
          status_nxt                 = ST_REMOVED;
          if (t_is_tail) begin
            tail_nxt = prev_r;
          end else begin
            // fetch the successor to splice past the removed slot
            link_re    = 1'b1;
            link_raddr = to_idx(task_r);
          end
        end else begin
          prev_nxt = rd_data_r;
        end
      end
      S_LINK: begin
        link_we    = 1'b1;
        link_waddr = to_idx(prev_r);
        link_wdata = rd_data_r;
      end
      S_RESP: begin
        if (out_free) begin
          out_status_nxt = status_r;
          out_task_nxt   = popped_r;
          out_valid_nxt  = 1'b1;
        end
      end
      default: begin
        status_nxt = status_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      empty_r     <= 1'b1;
      queued_r    <= '0;
      out_valid_r <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      empty_r     <= empty_nxt;
      queued_r    <= queued_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    task_r       <= task_nxt;
    prev_r       <= prev_nxt;
    status_r     <= status_nxt;
    popped_r     <= popped_nxt;
    out_status_r <= out_status_nxt;
    out_task_r   <= out_task_nxt;
  end

  // Link memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_waddr] <= link_wdata;
    if (link_re) rd_data_r <= link_mem[link_raddr];
  end

  // An empty queue holds no members.
  a_empty_no_members: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && empty_r) |-> (queued_r == '0))
    else $error("empty queue with member flags set");

  // Head and tail of a non-empty queue are members.
  a_ends_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && !empty_r) |->
      (queued_r[to_idx(head_r)] && queued_r[to_idx(tail_r)]))
    else $error("queue end is not flagged as a member");

  // A result only appears after the response step.
  a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_RESP))
    else $error("result raised outside the response step");

endmodule
`default_nettype wire

>>> sim/run_queue_fifo_with_removal_core_test.sv
`timescale 1ns / 100ps
`default_nettype none
module run_queue_fifo_with_removal_core_test;
  import rqf_pkg::*;

  // Operation code with no meaning in the block: must answer not found.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int SLOTS = 256;
  // Worst remove: walk of every link, plus setup and response.
  localparam int DRAIN_CYCLES = 3 + 2 * SLOTS + 16;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [TASK_W-1:0] id;
  } sched_op_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [TASK_W-1:0] task_out;
  } answer_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [OP_W-1:0] in_operation;
  logic [TASK_W-1:0] in_task_id;
  logic out_valid;
  logic out_ready;
  logic [ST_W-1:0] out_status;
  logic [TASK_W-1:0] out_task_out;

  run_queue_fifo_with_removal_core #(
    .TASK_SLOTS(SLOTS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_operation(in_operation),
    .in_task_id(in_task_id),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_task_out(out_task_out)
  );

  // Pending stimulus and the answers the queue owes us, oldest first.
  sched_op_t op_backlog[$];
  answer_t answer_queue[$];
  sched_op_t next_op;
  bit op_taken;
  int cycle_count;
  int fail_count;
  bit calm;

  // Shadow copy of the run queue.
  logic [TASK_W-1:0] rq_head;
  logic [TASK_W-1:0] rq_tail;
  bit rq_empty;
  bit rq_member[SLOTS];
  logic [TASK_W-1:0] rq_next[SLOTS];

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // No idling on either side during this window of cycles.
  assign calm = (cycle_count >= 4000) && (cycle_count < 12000);

  // Unlink the head and hand it back; the caller knows the queue is not empty.
  task automatic pop_head(output logic [TASK_W-1:0] slot);
    slot = rq_head;
    if (rq_head == rq_tail) begin
      rq_empty = 1'b1;
    end else begin
      rq_head = rq_next[rq_head];
    end
    rq_member[slot] = 1'b0;
  endtask

  // Apply one accepted item to the shadow queue and record the answer it owes.
  task automatic queue_apply(input logic [OP_W-1:0] op, input logic [TASK_W-1:0] id);
    answer_t ans;
    logic [TASK_W-1:0] prev;
    logic [TASK_W-1:0] slot;
    bit found;
    int steps;
    ans.status = ST_NOT_FOUND;
    ans.task_out = '0;
    found = 1'b0;
    case (op)
      OP_ENQUEUE: begin
        if (rq_member[id]) begin
          ans.status = ST_ALREADY;
        end else begin
          if (rq_empty) begin
            rq_head = id;
            rq_empty = 1'b0;
          end else begin
            rq_next[rq_tail] = id;
          end
          rq_tail = id;
          rq_member[id] = 1'b1;
          ans.status = ST_ENQUEUED;
        end
      end
      OP_DEQUEUE: begin
        if (rq_empty) begin
          ans.status = ST_EMPTY;
        end else begin
          pop_head(slot);
          ans.status = ST_DEQUEUED;
          ans.task_out = slot;
        end
      end
      OP_REMOVE: begin
        if (rq_member[id] && !rq_empty) begin
          if (id == rq_head) begin
            pop_head(slot);
            ans.status = ST_REMOVED;
          end else begin
            // Walk from the head to find the predecessor.
            prev = rq_head;
            for (steps = 0; steps < SLOTS && !found && prev != rq_tail; steps++) begin
              if (rq_next[prev] == id) found = 1'b1;
              else prev = rq_next[prev];
            end
            if (found) begin
              if (id == rq_tail) rq_tail = prev;
              else rq_next[prev] = rq_next[id];
              rq_member[id] = 1'b0;
              ans.status = ST_REMOVED;
            end
          end
        end
      end
      default: begin
        ans.status = ST_NOT_FOUND;
      end
    endcase
    answer_queue.push_back(ans);
  endtask

  task automatic add_op(input logic [OP_W-1:0] op, input logic [TASK_W-1:0] id);
    sched_op_t s;
    s.op = op;
    s.id = id;
    op_backlog.push_back(s);
  endtask

  // Build random segments: each one works on a pool of slots with a bias
  // that fills, drains or churns the queue, so that hits are common.
  task automatic add_random_ops(input int total);
    int added;
    int seg_len;
    int pool;
    int base;
    int mode;
    int roll;
    int k;
    logic [OP_W-1:0] op;
    added = 0;
    while (added < total) begin
      case ($urandom_range(3))
        0: pool = 4;
        1: pool = 16;
        2: pool = 64;
        default: pool = SLOTS;
      endcase
      base = $urandom_range(SLOTS - pool);
      seg_len = $urandom_range(80, 20);
      mode = $urandom_range(2);
      for (k = 0; k < seg_len && added < total; k++) begin
        roll = $urandom_range(99);
        if (roll < 5) begin
          op = OP_UNUSED;
        end else if (mode == 0) begin
          op = (roll < 75) ? OP_ENQUEUE : (roll < 85) ? OP_DEQUEUE : OP_REMOVE;
        end else if (mode == 1) begin
          op = (roll < 20) ? OP_ENQUEUE : (roll < 70) ? OP_DEQUEUE : OP_REMOVE;
        end else begin
          op = (roll < 45) ? OP_ENQUEUE : (roll < 70) ? OP_DEQUEUE : OP_REMOVE;
        end
        add_op(op, TASK_W'(base + $urandom_range(pool - 1)));
        added++;
      end
    end
  endtask

  // Driver: present items at the falling edge, hold each until it is taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || op_taken) begin
      op_taken = 1'b0;
      if (op_backlog.size() != 0 && (calm || $urandom_range(99) >= 16)) begin
        next_op = op_backlog.pop_front();
        in_valid <= 1'b1;
        in_operation <= next_op.op;
        in_task_id <= next_op.id;
      end else begin
        // Idle: drop valid and scramble the payload.
        in_valid <= 1'b0;
        in_operation <= OP_W'($urandom);
        in_task_id <= TASK_W'($urandom);
      end
    end
  end

  // Receiver back-pressure.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 16);
    end
  end

  // Monitor: predict on each accepted item, check each delivered result.
  always @(posedge clk) begin
    answer_t exp_ans;
    if (rst_n) begin
      cycle_count++;
      if (in_valid && in_ready) begin
        queue_apply(in_operation, in_task_id);
        op_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        if (answer_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: status %0d task %0d", out_status, out_task_out);
        end else begin
          exp_ans = answer_queue.pop_front();
          if (out_status !== exp_ans.status || out_task_out !== exp_ans.task_out) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected status %0d task %0d, got status %0d task %0d",
                       exp_ans.status, exp_ans.task_out, out_status, out_task_out);
          end
        end
      end
    end
  end

  initial begin
    int i;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = '0;
    in_task_id = '0;
    out_ready = 1'b0;
    op_taken = 1'b0;
    cycle_count = 0;
    fail_count = 0;
    rq_head = '0;
    rq_tail = '0;
    rq_empty = 1'b1;
    for (i = 0; i < SLOTS; i++) begin
      rq_member[i] = 1'b0;
      rq_next[i] = '0;
    end

    // Directed: empty queue, extreme slots, duplicates, removal from
    // middle, tail and head, unknown opcode, relink after a tail change.
    add_op(OP_DEQUEUE, 8'd0);
    add_op(OP_REMOVE, 8'd5);
    add_op(OP_ENQUEUE, 8'd0);
    add_op(OP_ENQUEUE, 8'd0);
    add_op(OP_ENQUEUE, 8'd255);
    add_op(OP_ENQUEUE, 8'd17);
    add_op(OP_ENQUEUE, 8'd42);
    add_op(OP_ENQUEUE, 8'd128);
    add_op(OP_REMOVE, 8'd42);
    add_op(OP_REMOVE, 8'd128);
    add_op(OP_REMOVE, 8'd0);
    add_op(OP_REMOVE, 8'd99);
    add_op(OP_UNUSED, 8'd255);
    add_op(OP_ENQUEUE, 8'd42);
    add_op(OP_ENQUEUE, 8'd85);
    add_op(OP_DEQUEUE, 8'd255);
    add_op(OP_DEQUEUE, 8'd0);
    add_op(OP_REMOVE, 8'd85);
    add_op(OP_DEQUEUE, 8'd0);
    add_op(OP_DEQUEUE, 8'd0);
    add_op(OP_ENQUEUE, 8'd170);
    add_op(OP_REMOVE, 8'd170);
    add_op(OP_DEQUEUE, 8'd0);
    add_random_ops(900);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for every item to go in and every answer to come back.
    while (op_backlog.size() != 0 || in_valid) @(posedge clk);
    while (answer_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #60_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
`default_nettype wire

>>> filelist.f
hw/rtl/rqf_pkg.sv
hw/rtl/run_queue_fifo_with_removal_core.sv
sim/run_queue_fifo_with_removal_core_test.sv
